// ----- sv/dearr_pkg.sv -----
package dearr_pkg;

  localparam int DEF_DEPTH     = 64;
  localparam int DEF_WORD_BITS = 32;

  localparam int OP_BITS     = 3;
  localparam int VALUE_BITS  = 32;
  localparam int INDEX_BITS  = 6;
  localparam int POS_BITS    = 7;
  localparam int COUNT_BITS  = 7;
  localparam int STATUS_BITS = 2;

  localparam logic [OP_BITS-1:0] OP_PUSH_BACK  = 3'd0;
  localparam logic [OP_BITS-1:0] OP_POP_BACK   = 3'd1;
  localparam logic [OP_BITS-1:0] OP_PUSH_FRONT = 3'd2;
  localparam logic [OP_BITS-1:0] OP_POP_FRONT  = 3'd3;
  localparam logic [OP_BITS-1:0] OP_READ       = 3'd4;
  localparam logic [OP_BITS-1:0] OP_WRITE      = 3'd5;
  localparam logic [OP_BITS-1:0] OP_FIND       = 3'd6;

  localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd2;
  localparam logic [STATUS_BITS-1:0] ST_RANGE = 2'd3;

  localparam logic [POS_BITS-1:0] POS_NONE = '1;

endpackage

// ----- sv/double_ended_array_with_search.sv -----
// Ordered list of up to DEPTH signed words held as a ring in one synchronous RAM, so pushes
// and pops at either end move a head pointer instead of the entries. One transaction is
// accepted when start is high and busy is low; its single result appears on the out_ ports
// for exactly one cycle with out_valid high and must be taken then, since the receiver
// cannot stall the block. Push, pop and write leave busy low and may follow back to back;
// a read passes through the S_READ state to wait for the RAM read data; find walks the list
// one entry per cycle through the RAM read port and keeps busy high until a match is found
// or the last entry is compared. Rejected operations change nothing and report a status code.
module double_ended_array_with_search #(
  parameter int DEPTH     = dearr_pkg::DEF_DEPTH,
  parameter int WORD_BITS = dearr_pkg::DEF_WORD_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [dearr_pkg::OP_BITS-1:0]        in_operation,
  input  logic signed [dearr_pkg::VALUE_BITS-1:0] in_value,
  input  logic [dearr_pkg::INDEX_BITS-1:0]     in_index,
  output logic                                 out_valid,
  output logic signed [dearr_pkg::VALUE_BITS-1:0] out_read_data,
  output logic signed [dearr_pkg::POS_BITS-1:0] out_found_position,
  output logic [dearr_pkg::COUNT_BITS-1:0]     out_count,
  output logic [dearr_pkg::STATUS_BITS-1:0]    out_status
);

  import dearr_pkg::*;

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > INDEX_BITS) ? CW : INDEX_BITS;

  localparam logic [AW:0]   DEPTH_A = (AW + 1)'(DEPTH);
  localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_FIND = 2'd2;

  logic [1:0]           state_r, state_nxt;
  logic [AW-1:0]        head_r, head_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [CW-1:0]        scan_r, scan_nxt;
  logic                 cmp_vld_r, cmp_vld_nxt;
  logic [CW-1:0]        cmp_idx_r, cmp_idx_nxt;
  logic [WORD_BITS-1:0] val_r, val_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic [VALUE_BITS-1:0]   out_rd_r, out_rd_nxt;
  logic [POS_BITS-1:0]     out_pos_r, out_pos_nxt;
  logic [COUNT_BITS-1:0]   out_cnt_r, out_cnt_nxt;
  logic [STATUS_BITS-1:0]  out_st_r, out_st_nxt;

  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic [AW-1:0]        mem_raddr;
  logic [WORD_BITS-1:0] mem_rdata;

  logic                 accept;
  logic [WORD_BITS-1:0] in_word;
  logic                 is_full;
  logic                 is_empty;
  logic                 idx_bad;
  logic signed [WORD_BITS-1:0] rdata_s;

  // Logical position counted from the front mapped onto the ring.
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] head, input logic [AW-1:0] lg);
    logic [AW:0] sum;
    sum = {1'b0, head} + {1'b0, lg};
    if (sum >= DEPTH_A) begin
      sum = sum - DEPTH_A;
    end
    return sum[AW-1:0];
  endfunction

  dearr_mem #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS),
    .AW        (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign busy     = (state_r != S_IDLE);
  assign accept   = start && !busy;
  assign in_word  = WORD_BITS'(in_value);
  assign is_full  = (cnt_r == DEPTH_C);
  assign is_empty = (cnt_r == '0);
  assign idx_bad  = (CMPW'(in_index) >= CMPW'(cnt_r));
  assign rdata_s  = mem_rdata;

  always_comb begin
    state_nxt   = state_r;
    head_nxt    = head_r;
    cnt_nxt     = cnt_r;
    scan_nxt    = scan_r;
    cmp_vld_nxt = cmp_vld_r;
    cmp_idx_nxt = cmp_idx_r;
    val_nxt     = val_r;

    out_valid_nxt = 1'b0;
    out_rd_nxt    = out_rd_r;
    out_pos_nxt   = out_pos_r;
    out_cnt_nxt   = out_cnt_r;
    out_st_nxt    = out_st_r;

    mem_we    = 1'b0;
    mem_waddr = phys(head_r, AW'(cnt_r));
    mem_wdata = in_word;
    mem_raddr = phys(head_r, AW'(in_index));

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_rd_nxt  = '0;
          out_pos_nxt = '0;
          out_st_nxt  = ST_OK;
          case (in_operation)
            OP_PUSH_BACK: begin
              if (is_full) begin
                out_st_nxt = ST_FULL;
              end else begin
                mem_we  = 1'b1;
                cnt_nxt = cnt_r + 1'b1;
              end
            end
            OP_POP_BACK: begin
              if (is_empty) begin
                out_st_nxt = ST_EMPTY;
              end else begin
                cnt_nxt = cnt_r - 1'b1;
              end
            end
            OP_PUSH_FRONT: begin
              if (is_full) begin
                out_st_nxt = ST_FULL;
              end else begin
                head_nxt  = (head_r == '0) ? LAST_A : head_r - 1'b1;
                mem_we    = 1'b1;
                mem_waddr = head_nxt;
                cnt_nxt   = cnt_r + 1'b1;
              end
            end
            OP_POP_FRONT: begin
              if (is_empty) begin
                out_st_nxt = ST_EMPTY;
              end else begin
                head_nxt = (head_r == LAST_A) ? '0 : head_r + 1'b1;
                cnt_nxt  = cnt_r - 1'b1;
              end
            end
            OP_READ: begin
              if (idx_bad) begin
                out_st_nxt = ST_RANGE;
              end else begin
                state_nxt = S_READ;
              end
            end
            OP_WRITE: begin
              if (idx_bad) begin
                out_st_nxt = ST_RANGE;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = phys(head_r, AW'(in_index));
              end
            end
            OP_FIND: begin
              state_nxt   = S_FIND;
              val_nxt     = in_word;
              scan_nxt    = '0;
              cmp_vld_nxt = 1'b0;
            end
            default: begin
            end
          endcase
          out_cnt_nxt = COUNT_BITS'(cnt_nxt);
          // Read and find report once their RAM accesses are done.
          out_valid_nxt = (state_nxt == S_IDLE);
        end
      end
      S_READ: begin
        out_valid_nxt = 1'b1;
        out_rd_nxt    = VALUE_BITS'(rdata_s);
        state_nxt     = S_IDLE;
      end
      S_FIND: begin
        // Reads are issued one entry ahead of the compare.
        mem_raddr = phys(head_r, AW'(scan_r));
        if (cmp_vld_r && (mem_rdata == val_r)) begin
          out_valid_nxt = 1'b1;
          out_pos_nxt   = POS_BITS'(cmp_idx_r);
          cmp_vld_nxt   = 1'b0;
          state_nxt     = S_IDLE;
        end else if (scan_r < cnt_r) begin
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = scan_r;
          scan_nxt    = scan_r + 1'b1;
        end else if (cmp_vld_r) begin
          cmp_vld_nxt = 1'b0;
        end else begin
          out_valid_nxt = 1'b1;
          out_pos_nxt   = POS_NONE;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      cnt_r       <= '0;
      scan_r      <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      cnt_r       <= cnt_nxt;
      scan_r      <= scan_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r <= cmp_idx_nxt;
    val_r     <= val_nxt;
    out_rd_r  <= out_rd_nxt;
    out_pos_r <= out_pos_nxt;
    out_cnt_r <= out_cnt_nxt;
    out_st_r  <= out_st_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_read_data      = out_rd_r;
  assign out_found_position = out_pos_r;
  assign out_count          = out_cnt_r;
  assign out_status         = out_st_r;

endmodule

// ----- sv/dearr_mem.sv -----
module dearr_mem #(
  parameter int DEPTH     = dearr_pkg::DEF_DEPTH,
  parameter int WORD_BITS = dearr_pkg::DEF_WORD_BITS,
  parameter int AW        = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  logic [WORD_BITS-1:0] wdata,
  input  logic [AW-1:0]        raddr,
  output logic [WORD_BITS-1:0] rdata
);

  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [WORD_BITS-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
